// File: rtl/ascii_hex_reply_frame_parser_core_macros.svh
// Assertion macros shared by the frame parser RTL.
`ifndef ASCII_HEX_REPLY_FRAME_PARSER_CORE_MACROS_SVH
`define ASCII_HEX_REPLY_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define AHRFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define AHRFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ahrfp_pkg.sv
// Types, constants and character helpers for the reply frame parser.
`default_nettype none

package ahrfp_pkg;

    localparam logic [7:0] CHAR_CR     = 8'd13;
    localparam logic [3:0] HEAD_LEN    = 4'd6;
    localparam logic [3:0] DATA_START  = 4'd8;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_HEAD_ERR  = 2'd1,
        ST_CHECK_ERR = 2'd2,
        ST_COUNT_ERR = 2'd3
    } t_frame_status;

    // Expected character of the fixed frame head "%01$RD".
    function automatic logic [7:0] head_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h25;
            3'd1:    c = 8'h30;
            3'd2:    c = 8'h31;
            3'd3:    c = 8'h24;
            3'd4:    c = 8'h52;
            3'd5:    c = 8'h44;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Upper-case hex spelling of one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10) begin
            c = 8'h30 + {4'd0, v};
        end else begin
            c = 8'h37 + {4'd0, v};
        end
        return c;
    endfunction

    // Nibble value of a data character; anything above '9' is taken as a letter.
    function automatic logic [3:0] char_nibble(input logic [7:0] c);
        logic [7:0] d;
        if (c > 8'h39) begin
            d = c - 8'h37;
        end else begin
            d = c - 8'h30;
        end
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/ascii_hex_reply_frame_parser_core.sv
// A result is registered in the output register, or in the skid register if that is held.
// Throughput: one character per cycle while the skid register is empty; the two-entry
// output (result register plus skid register) lets characters flow while one result waits.
// Reset: i_rst_n is synchronous and active low; it clears the frame state, empties the
// output stage and sets the expected word count to 1.
`default_nettype none

`include "ascii_hex_reply_frame_parser_core_macros.svh"

module ascii_hex_reply_frame_parser_core
    import ahrfp_pkg::*;
#(
    parameter int MAX_READ_WORDS = 26
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_data,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_char,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic [31:0]      o_data_word,
    output logic             o_is_word,
    output logic [1:0]       o_frame_status,
    output logic             o_last
);

    localparam logic [7:0] WORD_CAP = 8'(MAX_READ_WORDS / 2);

    // Frame state.
    logic [3:0]  r_exp_words;
    logic [3:0]  r_pos,    n_pos;
    logic [7:0]  r_xor,    n_xor;
    logic [7:0]  r_prev0,  n_prev0;
    logic [7:0]  r_prev1,  n_prev1;
    logic        r_head_ok, n_head_ok;
    logic [31:0] r_group,  n_group;
    logic [2:0]  r_gcnt,   n_gcnt;
    logic [7:0]  r_words,  n_words;

    // Output stage.
    logic          r_out_valid, r_skid_valid;
    logic [31:0]   r_out_word,  r_skid_word;
    logic          r_out_isw,   r_skid_isw;
    t_frame_status r_out_status, r_skid_status;

    // Result of the current character.
    logic          res_gen;
    logic [31:0]   res_word;
    logic          res_isw;
    t_frame_status res_status;

    logic        accept;
    logic        out_take;
    logic [7:0]  chk_x;
    logic [31:0] full_word;
    logic [4:0]  shift;

    assign o_rx_ready = !r_skid_valid;
    assign accept     = i_rx_valid && o_rx_ready;
    assign out_take   = r_out_valid && i_res_ready;

    assign chk_x     = r_xor ^ r_prev0 ^ r_prev1;
    // Pairs are bytes, low byte first; the first character of a pair is the high nibble.
    assign shift     = {r_gcnt[2:1], ~r_gcnt[0], 2'b00};
    assign full_word = r_group | (32'(char_nibble(r_prev1)) << shift);

    always_comb begin
        n_pos      = r_pos;
        n_xor      = r_xor;
        n_prev0    = r_prev0;
        n_prev1    = r_prev1;
        n_head_ok  = r_head_ok;
        n_group    = r_group;
        n_gcnt     = r_gcnt;
        n_words    = r_words;
        res_gen    = 1'b0;
        res_word   = 32'd0;
        res_isw    = 1'b0;
        res_status = ST_OK;
        if (accept) begin
            if (i_rx_char == CHAR_CR) begin
                res_gen = 1'b1;
                if (r_pos <= HEAD_LEN || !r_head_ok) begin
                    res_status = ST_HEAD_ERR;
                end else if (r_prev1 != hex_char(chk_x[7:4]) ||
                             r_prev0 != hex_char(chk_x[3:0])) begin
                    res_status = ST_CHECK_ERR;
                end else if (r_words != {4'd0, r_exp_words}) begin
                    res_status = ST_COUNT_ERR;
                end
                n_pos     = '0;
                n_xor     = '0;
                n_prev0   = '0;
                n_prev1   = '0;
                n_head_ok = 1'b1;
                n_group   = '0;
                n_gcnt    = '0;
                n_words   = '0;
            end else begin
                if (r_pos < HEAD_LEN && i_rx_char != head_char(r_pos[2:0])) begin
                    n_head_ok = 1'b0;
                end
                // The character two back is data once two more non-CR characters followed it.
                if (r_pos >= DATA_START) begin
                    if (r_gcnt == 3'd7) begin
                        if (r_words < WORD_CAP) begin
                            res_gen  = 1'b1;
                            res_isw  = 1'b1;
                            res_word = full_word;
                        end
                        if (r_words != 8'hFF) begin
                            n_words = r_words + 8'd1;
                        end
                        n_group = '0;
                        n_gcnt  = '0;
                    end else begin
                        n_group = full_word;
                        n_gcnt  = r_gcnt + 3'd1;
                    end
                end
                n_prev1 = r_prev0;
                n_prev0 = i_rx_char;
                n_xor   = r_xor ^ i_rx_char;
                if (r_pos != DATA_START) begin
                    n_pos = r_pos + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_words <= 4'd1;
            r_pos       <= '0;
            r_xor       <= '0;
            r_prev0     <= '0;
            r_prev1     <= '0;
            r_head_ok   <= 1'b1;
            r_group     <= '0;
            r_gcnt      <= '0;
            r_words     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_exp_words <= i_cfg_data;
            end
            r_pos     <= n_pos;
            r_xor     <= n_xor;
            r_prev0   <= n_prev0;
            r_prev1   <= n_prev1;
            r_head_ok <= n_head_ok;
            r_group   <= n_group;
            r_gcnt    <= n_gcnt;
            r_words   <= n_words;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_gen;
            end
        end else if (res_gen) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_word   <= r_skid_word;
                r_out_isw    <= r_skid_isw;
                r_out_status <= r_skid_status;
            end else begin
                r_out_word   <= res_word;
                r_out_isw    <= res_isw;
                r_out_status <= res_status;
            end
        end else if (res_gen) begin
            r_skid_word   <= res_word;
            r_skid_isw    <= res_isw;
            r_skid_status <= res_status;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_data_word    = r_out_word;
    assign o_is_word      = r_out_isw;
    assign o_frame_status = r_out_status;
    assign o_last         = !r_out_isw;

    `AHRFP_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid,
        "skid entry holds a result while the output register is empty")
    `AHRFP_ASSERT_NOW(a_word_result_clean, r_out_valid && r_out_isw,
        r_out_status == ST_OK, "word result carries a nonzero frame status")
    `AHRFP_ASSERT_NEXT(a_cr_clears_frame, accept && i_rx_char == CHAR_CR,
        r_pos == 4'd0 && r_words == 8'd0 && r_gcnt == 3'd0 && r_head_ok,
        "frame state not cleared after the end-of-frame character")
    `AHRFP_ASSERT_NOW(a_pos_saturates, 1'b1, r_pos <= DATA_START,
        "character position counter ran past its saturation value")
    `AHRFP_ASSERT_NOW(a_group_only_in_data, r_pos < DATA_START,
        r_gcnt == 3'd0 && r_group == 32'd0, "data group filled before data confirmation")

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the ASCII-hex reply frame parser core.
`timescale 1ns / 1ps

module testbench
    import ahrfp_pkg::*;
();

    localparam int READ_WORD_LIMIT = 26;
    localparam int TARGET_CHARS    = 1750;
    localparam int PHASES          = 8;
    localparam int SETTLE_CYCLES   = 6;
    localparam int LONG_HOLD       = 400;
    localparam int TIMEOUT_NS      = 1_000_000;

    localparam logic [7:0] FRAME_HEAD [6] = '{"%", "0", "1", "$", "R", "D"};
    localparam logic [7:0] HEX_SPELLING [16] = '{"0", "1", "2", "3", "4", "5", "6", "7",
                                                 "8", "9", "A", "B", "C", "D", "E", "F"};

    typedef struct {
        logic [31:0]   data_word;
        logic          is_word;
        t_frame_status frame_status;
        logic          last;
    } t_frame_result;

    typedef enum {
        FRAME_CLEAN,
        FRAME_BAD_HEAD,
        FRAME_BAD_CHECK,
        FRAME_NOISE,
        FRAME_SHORT,
        FRAME_LONG
    } t_frame_kind;

    typedef enum {
        SINK_FREE,
        SINK_COIN,
        SINK_THIRD,
        SINK_SPARSE
    } t_sink_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_data;
    logic        i_rx_valid;
    logic        o_rx_ready;
    logic [7:0]  i_rx_char;
    logic        o_res_valid;
    logic        i_res_ready;
    logic [31:0] o_data_word;
    logic        o_is_word;
    logic [1:0]  o_frame_status;
    logic        o_last;

    function automatic logic [7:0] spell_nibble(input logic [3:0] v);
        return HEX_SPELLING[v];
    endfunction

    // Tracks one frame at a time and queues the results the parser should give.
    class t_frame_scoreboard;
        logic [3:0]    word_count_cfg;
        int            chars_in_frame;
        logic [7:0]    xor_acc;
        logic [7:0]    newest;
        logic [7:0]    older;
        bit            head_match;
        logic [31:0]   word_build;
        int            group_len;
        int            groups_done;
        t_frame_result pending_q[$];
        int            failures;
        int            words_checked;
        int            status_seen[4];

        function new();
            word_count_cfg = 4'd1;
            failures = 0;
            words_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            chars_in_frame = 0;
            xor_acc = 8'h00;
            newest = 8'h00;
            older = 8'h00;
            head_match = 1'b1;
            word_build = 32'h0;
            group_len = 0;
            groups_done = 0;
        endfunction

        function logic [3:0] nibble_value(input logic [7:0] c);
            logic [7:0] v;
            if (c > "9") begin
                v = c - "A" + 8'd10;
            end else begin
                v = c - "0";
            end
            return v[3:0];
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        function void queue_result(input t_frame_result r);
            pending_q = {pending_q, r};
        endfunction

        function void note_char(input logic [7:0] c);
            t_frame_result r;
            logic [7:0]    body;
            int            slot;
            r.data_word = 32'h0;
            r.is_word = 1'b0;
            r.frame_status = ST_OK;
            r.last = 1'b0;
            if (c == CHAR_CR) begin
                r.last = 1'b1;
                if (chars_in_frame <= 6 || !head_match) begin
                    r.frame_status = ST_HEAD_ERR;
                end else begin
                    // The check characters themselves are left out of the XOR.
                    body = xor_acc ^ newest ^ older;
                    if (older != spell_nibble(body[7:4]) || newest != spell_nibble(body[3:0])) begin
                        r.frame_status = ST_CHECK_ERR;
                    end else if (groups_done != int'(word_count_cfg)) begin
                        r.frame_status = ST_COUNT_ERR;
                    end
                end
                queue_result(r);
                restart_frame();
                return;
            end
            if (chars_in_frame < 6 && c != FRAME_HEAD[chars_in_frame]) head_match = 1'b0;
            // A character is known to be data only once two more have followed it.
            if (chars_in_frame >= 8) begin
                slot = group_len;
                word_build |= 32'(nibble_value(older)) << ((slot / 2) * 8 + ((slot % 2 == 0) ? 4 : 0));
                if (slot == 7) begin
                    if (groups_done < READ_WORD_LIMIT / 2) begin
                        r.data_word = word_build;
                        r.is_word = 1'b1;
                        queue_result(r);
                    end
                    if (groups_done < 255) groups_done++;
                    word_build = 32'h0;
                    group_len = 0;
                end else begin
                    group_len = slot + 1;
                end
            end
            older = newest;
            newest = c;
            xor_acc ^= c;
            if (chars_in_frame < 255) chars_in_frame++;
        endfunction

        function void check_result(input t_frame_result got);
            t_frame_result want;
            if (pending_q.size() == 0) begin
                $error("result with nothing outstanding: data_word %h is_word %b status %0d last %b",
                       got.data_word, got.is_word, got.frame_status, got.last);
                failures++;
                return;
            end
            want = pending_q.pop_front();
            if (got.data_word !== want.data_word) begin
                $error("data_word: expected %h, actual %h", want.data_word, got.data_word);
                failures++;
            end
            if (got.is_word !== want.is_word) begin
                $error("is_word: expected %b, actual %b", want.is_word, got.is_word);
                failures++;
            end
            if (got.frame_status !== want.frame_status) begin
                $error("frame_status: expected %0d, actual %0d", want.frame_status, got.frame_status);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, actual %b", want.last, got.last);
                failures++;
            end
            if (want.last) status_seen[want.frame_status]++;
            else words_checked++;
        endfunction
    endclass

    t_frame_scoreboard board = new();

    logic [7:0] frame_chars[$];
    int         chars_sent = 0;
    int         burst_left = 0;
    int         hold_requests = 0;

    ascii_hex_reply_frame_parser_core #(
        .MAX_READ_WORDS(READ_WORD_LIMIT)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_char      (i_rx_char),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_data_word    (o_data_word),
        .o_is_word      (o_is_word),
        .o_frame_status (o_frame_status),
        .o_last         (o_last)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin : result_monitor
        t_frame_result got;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            got.data_word = o_data_word;
            got.is_word = o_is_word;
            got.frame_status = t_frame_status'(o_frame_status);
            got.last = o_last;
            board.check_result(got);
        end
    end

    // The result side switches between stall patterns; a requested hold-off blocks it long
    // enough for the output stage to fill and back up into the character input.
    initial begin : result_sink
        t_sink_mode mode;
        int         mode_left;
        int         tick;
        int         holds_served;
        i_res_ready = 1'b0;
        mode = SINK_FREE;
        mode_left = 0;
        tick = 0;
        holds_served = 0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                i_res_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode = t_sink_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                tick++;
                case (mode)
                    SINK_FREE:  i_res_ready <= 1'b1;
                    SINK_COIN:  i_res_ready <= 1'($urandom_range(0, 1));
                    SINK_THIRD: i_res_ready <= (tick % 3 == 0);
                    default:    i_res_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", board.pending());
        $display("status: fail");
        $finish;
    end

    function automatic logic [7:0] any_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CHAR_CR);
        return c;
    endfunction

    function automatic void add_frame_char(input logic [7:0] c);
        frame_chars = {frame_chars, c};
    endfunction

    // Offers one character and returns once it is taken; the sender runs in bursts.
    task automatic send_char(input logic [7:0] c);
        int gap;
        @(negedge i_clk);
        i_rx_valid <= 1'b1;
        i_rx_char <= c;
        do @(posedge i_clk); while (!o_rx_ready);
        board.note_char(c);
        chars_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_rx_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_frame();
        foreach (frame_chars[i]) send_char(frame_chars[i]);
    endtask

    task automatic build_frame(input t_frame_kind kind, input int words, input int leftover);
        logic [7:0] sum;
        logic [7:0] c;
        int         spoil;
        int         len;
        frame_chars.delete();
        case (kind)
            FRAME_NOISE: begin
                len = $urandom_range(0, 24);
                repeat (len) add_frame_char(any_char());
            end
            FRAME_SHORT: begin
                len = $urandom_range(0, 7);
                for (int i = 0; i < len; i++) begin
                    add_frame_char((i < 6) ? FRAME_HEAD[i] : any_char());
                end
            end
            default: begin
                for (int i = 0; i < 6; i++) add_frame_char(FRAME_HEAD[i]);
                if (kind == FRAME_BAD_HEAD) begin
                    spoil = $urandom_range(0, 5);
                    do c = any_char(); while (c == FRAME_HEAD[spoil]);
                    frame_chars[spoil] = c;
                end
                // Mostly upper-case hex, with the odd arbitrary byte mixed in.
                repeat (words * 8 + leftover) begin
                    if ($urandom_range(0, 15) == 0) add_frame_char(any_char());
                    else add_frame_char(spell_nibble(4'($urandom_range(0, 15))));
                end
                sum = 8'h00;
                foreach (frame_chars[i]) sum ^= frame_chars[i];
                add_frame_char(spell_nibble(sum[7:4]));
                add_frame_char(spell_nibble(sum[3:0]));
                if (kind == FRAME_BAD_CHECK) begin
                    spoil = frame_chars.size() - 1 - $urandom_range(0, 1);
                    do c = any_char(); while (c == frame_chars[spoil]);
                    frame_chars[spoil] = c;
                end
            end
        endcase
        add_frame_char(CHAR_CR);
    endtask

    // Drops valid and waits until every expected result has been taken.
    task automatic drain_results();
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_word_count(input logic [3:0] n);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= n;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.word_count_cfg = n;
    endtask

    task automatic send_random_frame();
        int roll;
        int words;
        int leftover;
        roll = $urandom_range(0, 99);
        leftover = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (roll < 55) begin
            words = ($urandom_range(0, 1) == 1) ? int'(board.word_count_cfg)
                                                : $urandom_range(0, 15);
            build_frame(FRAME_CLEAN, words, leftover);
        end else if (roll < 65) begin
            build_frame(FRAME_BAD_HEAD, $urandom_range(0, 4), leftover);
        end else if (roll < 75) begin
            build_frame(FRAME_BAD_CHECK, $urandom_range(0, 4), leftover);
        end else if (roll < 85) begin
            build_frame(FRAME_NOISE, 0, 0);
        end else if (roll < 95) begin
            build_frame(FRAME_SHORT, 0, 0);
        end else begin
            // Past the word cap, and long enough for the position count to saturate.
            build_frame(FRAME_LONG, $urandom_range(14, 34), leftover);
        end
        send_frame();
    endtask

    initial begin : stimulus
        logic [3:0] count_plan [PHASES];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 4'd0;
        i_rx_valid = 1'b0;
        i_rx_char = 8'h00;
        count_plan = '{4'd1, 4'd13, 4'd0, 4'd15, 4'd7, 4'd14, 4'd1, 4'd0};
        count_plan[7] = 4'($urandom_range(0, 15));
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty frame, a short frame with extreme bytes, then one clean single-word frame.
        frame_chars = '{CHAR_CR};
        send_frame();
        frame_chars = '{"%", "0", 8'hFF, 8'h00, CHAR_CR};
        send_frame();
        build_frame(FRAME_CLEAN, 1, 0);
        send_frame();

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain_results();
                write_word_count(count_plan[p]);
            end
            if (p == 2) begin
                hold_requests++;
                build_frame(FRAME_CLEAN, 20, 0);
                send_frame();
            end
            while (chars_sent < (p + 1) * TARGET_CHARS / PHASES) begin
                send_random_frame();
                if ($urandom_range(0, 24) == 0) drain_results();
            end
        end
        drain_results();

        $display("sent %0d characters under %0d word-count settings; checked %0d words",
                 chars_sent, PHASES, board.words_checked);
        $display("frame endings ok/head/check/count: %0d/%0d/%0d/%0d",
                 board.status_seen[ST_OK], board.status_seen[ST_HEAD_ERR],
                 board.status_seen[ST_CHECK_ERR], board.status_seen[ST_COUNT_ERR]);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
